// File: sv/ambient_cancel_wall_sensor_assert.svh
`ifndef AMBIENT_CANCEL_WALL_SENSOR_ASSERT_SVH
`define AMBIENT_CANCEL_WALL_SENSOR_ASSERT_SVH

// same-cycle implication
`define ACWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/acws_pkg.sv
package acws_pkg;

    localparam int DARK_SAMPLES = 16;
    localparam int LIT_SAMPLES  = 16;
    localparam int ADC_BITS     = 12;

    localparam int N_CH       = 4;
    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 12;
    localparam int SUM_W      = 20;
    localparam int TICK_W     = 11;
    localparam int SETTLE_W   = 8;
    localparam int COUNT_W    = 16;
    localparam int EMIT_W     = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USED_W = EMIT_W + N_CH * LEVEL_W + COUNT_W;

    localparam logic [EMIT_W-1:0]   EMIT_OFF    = 4'h0;
    localparam logic [EMIT_W-1:0]   EMIT_PAIR_A = 4'h5;
    localparam logic [EMIT_W-1:0]   EMIT_PAIR_B = 4'hA;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd10;

    typedef logic [SAMPLE_W-1:0] t_sample;

    localparam t_sample SAMPLE_MASK = t_sample'((64'd1 << ADC_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_SETTLE_DARK,
        PH_SUM_DARK,
        PH_SETTLE_A,
        PH_SUM_A,
        PH_SETTLE_B,
        PH_SUM_B,
        PH_FINAL
    } t_phase;

    typedef struct packed {
        logic [EMIT_W-1:0]             emitter;
        logic [N_CH-1:0][LEVEL_W-1:0]  level;
        logic                          fresh;
        logic [COUNT_W-1:0]            count;
    } t_result;

endpackage

// File: sv/acws_phase.sv
module acws_phase (
    input  logic [acws_pkg::TICK_W-1:0]   i_tick,
    input  logic [acws_pkg::SETTLE_W-1:0] i_settle,
    output acws_pkg::t_phase              o_phase
);
    import acws_pkg::*;

    logic [TICK_W-1:0] w;
    logic [TICK_W-1:0] b_dark;
    logic [TICK_W-1:0] b_settle_a;
    logic [TICK_W-1:0] b_sum_a;
    logic [TICK_W-1:0] b_settle_b;
    logic [TICK_W-1:0] b_sum_b;

    always_comb begin
        w          = TICK_W'(i_settle);
        b_dark     = w + TICK_W'(DARK_SAMPLES);
        b_settle_a = b_dark + w;
        b_sum_a    = b_settle_a + TICK_W'(LIT_SAMPLES);
        b_settle_b = b_sum_a + w;
        b_sum_b    = b_settle_b + TICK_W'(LIT_SAMPLES);
    end

    always_comb begin
        priority if (i_tick <= w) begin
            o_phase = PH_SETTLE_DARK;
        end else if (i_tick <= b_dark) begin
            o_phase = PH_SUM_DARK;
        end else if (i_tick <= b_settle_a) begin
            o_phase = PH_SETTLE_A;
        end else if (i_tick <= b_sum_a) begin
            o_phase = PH_SUM_A;
        end else if (i_tick <= b_settle_b) begin
            o_phase = PH_SETTLE_B;
        end else if (i_tick <= b_sum_b) begin
            o_phase = PH_SUM_B;
        end else begin
            o_phase = PH_FINAL;
        end
    end

endmodule

// File: sv/acws_core.sv
`include "ambient_cancel_wall_sensor_assert.svh"

module acws_core (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_adv,
    input  logic [acws_pkg::N_CH-1:0][acws_pkg::SAMPLE_W-1:0] i_samples,
    input  logic [acws_pkg::SETTLE_W-1:0]                 i_settle,
    output acws_pkg::t_result                             o_result
);
    import acws_pkg::*;

    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  n_tick;
    logic [SUM_W-1:0]   r_dark [N_CH];
    logic [SUM_W-1:0]   n_dark [N_CH];
    logic [SUM_W-1:0]   r_lit  [N_CH];
    logic [SUM_W-1:0]   n_lit  [N_CH];
    logic [LEVEL_W-1:0] r_level [N_CH];
    logic [LEVEL_W-1:0] n_level [N_CH];
    logic [EMIT_W-1:0]  r_emit;
    logic [EMIT_W-1:0]  n_emit;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               fresh;
    logic [TICK_W-1:0]  tick_inc;
    logic [SUM_W-1:0]   dark_avg [N_CH];
    logic [SUM_W-1:0]   lit_avg  [N_CH];
    logic [SUM_W-1:0]   smp      [N_CH];
    t_phase             phase;

    assign tick_inc = r_tick + 1'b1;

    acws_phase u_phase (
        .i_tick   (tick_inc),
        .i_settle (i_settle),
        .o_phase  (phase)
    );

    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            smp[c]      = SUM_W'(i_samples[c] & SAMPLE_MASK);
            dark_avg[c] = SUM_W'(r_dark[c] / DARK_SAMPLES);
            lit_avg[c]  = SUM_W'(r_lit[c] / LIT_SAMPLES);
        end
    end

    always_comb begin
        n_tick  = tick_inc;
        n_emit  = r_emit;
        n_count = r_count;
        fresh   = 1'b0;
        for (int c = 0; c < N_CH; c++) begin
            n_dark[c]  = r_dark[c];
            n_lit[c]   = r_lit[c];
            n_level[c] = r_level[c];
        end
        unique case (phase)
            PH_SETTLE_DARK: n_emit = EMIT_OFF;
            PH_SUM_DARK: begin
                for (int c = 0; c < N_CH; c++) begin
                    n_dark[c] = r_dark[c] + smp[c];
                end
            end
            PH_SETTLE_A: n_emit = EMIT_PAIR_A;
            PH_SUM_A: begin
                n_lit[0] = r_lit[0] + smp[0];
                n_lit[2] = r_lit[2] + smp[2];
            end
            PH_SETTLE_B: n_emit = EMIT_PAIR_B;
            PH_SUM_B: begin
                n_lit[1] = r_lit[1] + smp[1];
                n_lit[3] = r_lit[3] + smp[3];
            end
            PH_FINAL: begin
                for (int c = 0; c < N_CH; c++) begin
                    n_level[c] = (lit_avg[c] > dark_avg[c]) ?
                                 LEVEL_W'(lit_avg[c] - dark_avg[c]) : '0;
                    n_dark[c]  = '0;
                    n_lit[c]   = '0;
                end
                n_tick  = '0;
                n_count = r_count + 1'b1;
                fresh   = 1'b1;
            end
            default: n_emit = r_emit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_emit  <= EMIT_OFF;
            r_count <= '0;
            for (int c = 0; c < N_CH; c++) begin
                r_dark[c]  <= '0;
                r_lit[c]   <= '0;
                r_level[c] <= '0;
            end
        end else if (i_adv) begin
            r_tick  <= n_tick;
            r_emit  <= n_emit;
            r_count <= n_count;
            for (int c = 0; c < N_CH; c++) begin
                r_dark[c]  <= n_dark[c];
                r_lit[c]   <= n_lit[c];
                r_level[c] <= n_level[c];
            end
        end
    end

    always_comb begin
        o_result.emitter = n_emit;
        for (int c = 0; c < N_CH; c++) begin
            o_result.level[c] = n_level[c];
        end
        o_result.fresh = fresh;
        o_result.count = n_count;
    end

    `ACWS_ASSERT_NEXT(a_final_restarts, i_clk, i_rst_n, i_adv && phase == PH_FINAL, r_tick == '0, "final word did not restart tick counter")
    `ACWS_ASSERT_NEXT(a_count_only_final, i_clk, i_rst_n, !(i_adv && phase == PH_FINAL), r_count == $past(r_count), "update count moved outside final word")
    `ACWS_ASSERT_NOW(a_emit_legal, i_clk, i_rst_n, 1'b1, r_emit == EMIT_OFF || r_emit == EMIT_PAIR_A || r_emit == EMIT_PAIR_B, "illegal emitter pattern")

endmodule

// File: sv/ambient_cancel_wall_sensor.sv
// Ambient-cancelling IR wall sensor sequencer.
// s_axis: one word per finished ADC conversion, four 12-bit receiver samples.
// m_axis: one word per input word: emitter pattern, four levels, update count;
//   tuser flags the word on which fresh levels were computed.
// cfg: write of settle_ticks (8 bits), taken at any time, always ready;
//   only change it while no word is in flight.
// Path: a word is registered in the input register, processed there by the
//   core, then taken into the m_axis output register when that can accept it.
// Throughput: one word per cycle while m_axis is ready; s_axis_tready is high
//   when the input register is empty or its word moves on in the same cycle.
// Receiver stall: the output register holds its word, the input register
//   holds one more, then s_axis_tready falls until m_axis_tready returns.
// Reset (i_rst_n low, synchronous): sums, levels, tick and update counters
//   cleared, emitters off, settle_ticks back to 10, both registers empty.
module ambient_cancel_wall_sensor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] front_left, [23:12] left, [35:24] right, [47:36] front_right
    input  logic [acws_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [3:0] emitter_pattern, [15:4] level_front_left, [27:16] level_left,
    // [39:28] level_right, [51:40] level_front_right, [67:52] update_count
    output logic [acws_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] levels_fresh
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [acws_pkg::SETTLE_W-1:0]       i_cfg_data
);
    import acws_pkg::*;

    logic                            r_in_vld;
    logic [IN_DATA_W-1:0]            r_in_data;
    logic                            r_out_vld;
    t_result                         r_out;
    logic [SETTLE_W-1:0]             r_settle;
    logic                            advance;
    logic                            take;
    logic [N_CH-1:0][SAMPLE_W-1:0]   samples;
    t_result                         result;

    assign advance       = !r_out_vld || m_axis_tready;
    assign take          = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            samples[c] = r_in_data[c*SAMPLE_W +: SAMPLE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_settle <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    acws_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (take),
        .i_samples (samples),
        .i_settle  (r_settle),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), r_out.count,
                            r_out.level, r_out.emitter};
    assign m_axis_tuser  = r_out.fresh;

endmodule

// File: verif/ambient_cancel_wall_sensor_test.sv
module ambient_cancel_wall_sensor_test;
    import acws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1750;
    localparam int CALM_TAIL    = 150;
    localparam int CYCLE_LIMIT  = 500000;

    typedef logic [N_CH-1:0][SAMPLE_W-1:0] t_quad;

    typedef struct {
        int    settle;
        t_quad smp;
        bit    typed;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]              m_axis_tuser;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [SETTLE_W-1:0]     i_cfg_data = '0;

    ambient_cancel_wall_sensor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sensor shadow state
    logic [SETTLE_W-1:0] settle_now = SETTLE_RESET;
    logic [TICK_W-1:0]   tick_now = '0;
    logic [SUM_W-1:0]    dark_acc [N_CH];
    logic [SUM_W-1:0]    lit_acc [N_CH];
    logic [EMIT_W-1:0]   lamp = EMIT_OFF;
    logic [LEVEL_W-1:0]  level_now [N_CH];
    logic [COUNT_W-1:0]  cycles_done = '0;

    t_result pending_readings [$];
    int      faults = 0;
    int      cycles = 0;
    bit      calm = 1'b0;
    int      hold_left = 0;

    int scene = 0;
    int haze [N_CH];
    int glint [N_CH];

    t_row plan [20] = '{
        '{-1,  48'h000000000000, 1},
        '{-1,  48'hFFFFFFFFFFFF, 1},
        '{-1,  48'hAAA555AAA555, 1},
        '{-1,  48'h555AAA555AAA, 1},
        '{-1,  48'hFFF000FFF000, 1},
        '{-1,  48'h000FFF000FFF, 1},
        '{-1,  48'h800800800800, 1},
        '{-1,  48'h001001001001, 1},
        '{0,   48'hFFFFFFFFFFFF, 0},
        '{-1,  48'hFFFFFFFFFFFF, 0},
        '{-1,  48'h000000000000, 0},
        '{-1,  48'h7FF7FF7FF7FF, 0},
        '{255, 48'h123456789ABC, 0},
        '{-1,  48'hFFFFFFFFFFFF, 0},
        '{-1,  48'h000000000000, 0},
        '{2,   48'hFFF000FFF000, 0},
        '{-1,  48'h004003002001, 0},
        '{-1,  48'hFFFFFFFFFFFF, 0},
        '{-1,  48'h000000000000, 0},
        '{-1,  48'h000000000000, 0}
    };

    function automatic t_result step_sensor(t_quad smp);
        t_result r;
        int w;
        int t;
        int dk;
        int lt;
        r = '0;
        w = settle_now;
        tick_now = tick_now + 1'b1;
        t = tick_now;
        r.fresh = 1'b0;
        if (t <= w) begin
            lamp = EMIT_OFF;
        end else if (t <= w + DARK_SAMPLES) begin
            for (int ch = 0; ch < N_CH; ch++)
                dark_acc[ch] = dark_acc[ch] + SUM_W'(smp[ch] & SAMPLE_MASK);
        end else if (t <= 2 * w + DARK_SAMPLES) begin
            lamp = EMIT_PAIR_A;
        end else if (t <= 2 * w + DARK_SAMPLES + LIT_SAMPLES) begin
            lit_acc[0] = lit_acc[0] + SUM_W'(smp[0] & SAMPLE_MASK);
            lit_acc[2] = lit_acc[2] + SUM_W'(smp[2] & SAMPLE_MASK);
        end else if (t <= 3 * w + DARK_SAMPLES + LIT_SAMPLES) begin
            lamp = EMIT_PAIR_B;
        end else if (t <= 3 * w + DARK_SAMPLES + 2 * LIT_SAMPLES) begin
            lit_acc[1] = lit_acc[1] + SUM_W'(smp[1] & SAMPLE_MASK);
            lit_acc[3] = lit_acc[3] + SUM_W'(smp[3] & SAMPLE_MASK);
        end else begin
            for (int ch = 0; ch < N_CH; ch++) begin
                dk = dark_acc[ch] / DARK_SAMPLES;
                lt = lit_acc[ch] / LIT_SAMPLES;
                level_now[ch] = (lt > dk) ? LEVEL_W'(lt - dk) : '0;
                dark_acc[ch] = '0;
                lit_acc[ch] = '0;
            end
            tick_now = '0;
            cycles_done = cycles_done + 1'b1;
            r.fresh = 1'b1;
        end
        r.emitter = lamp;
        for (int ch = 0; ch < N_CH; ch++)
            r.level[ch] = level_now[ch];
        r.count = cycles_done;
        return r;
    endfunction

    function automatic t_quad draw_samples();
        t_quad q;
        int v;
        for (int ch = 0; ch < N_CH; ch++) begin
            case (scene)
                0: begin
                    q[ch] = t_sample'($urandom);
                end
                1: begin
                    case ($urandom_range(0, 2))
                        0: q[ch] = '0;
                        1: q[ch] = SAMPLE_MASK;
                        default: q[ch] = t_sample'($urandom);
                    endcase
                end
                default: begin
                    v = haze[ch] + (lamp[ch] ? glint[ch] : 0) + int'($urandom_range(0, 80)) - 40;
                    if (v < 0) v = 0;
                    if (v > 4095) v = 4095;
                    q[ch] = t_sample'(v);
                end
            endcase
        end
        return q;
    endfunction

    function automatic void new_scene();
        scene = $urandom_range(0, 3);
        for (int ch = 0; ch < N_CH; ch++) begin
            haze[ch] = $urandom_range(0, 3000);
            glint[ch] = int'($urandom_range(0, 1800)) - 600;
        end
    endfunction

    task automatic offer_word(t_quad smp, bit typed);
        t_result want;
        t_result got;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        got = step_sensor(smp);
        if (typed) begin
            want = '0;
            want.emitter = EMIT_OFF;
            pending_readings.push_back(want);
        end else begin
            pending_readings.push_back(got);
        end
    endtask

    // drain, let the pipe go quiet, then write the settle time
    task automatic write_settle(logic [SETTLE_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settle_now = v;
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            faults++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("word with no reading pending");
                faults++;
            end else begin
                want = pending_readings.pop_front();
                check_field("emitter_pattern", want.emitter, m_axis_tdata[EMIT_W-1:0]);
                check_field("level_front_left", want.level[0],
                            m_axis_tdata[EMIT_W + 0 * LEVEL_W +: LEVEL_W]);
                check_field("level_left", want.level[1],
                            m_axis_tdata[EMIT_W + 1 * LEVEL_W +: LEVEL_W]);
                check_field("level_right", want.level[2],
                            m_axis_tdata[EMIT_W + 2 * LEVEL_W +: LEVEL_W]);
                check_field("level_front_right", want.level[3],
                            m_axis_tdata[EMIT_W + 3 * LEVEL_W +: LEVEL_W]);
                check_field("levels_fresh", want.fresh, m_axis_tuser[0]);
                check_field("update_count", want.count,
                            m_axis_tdata[EMIT_W + N_CH * LEVEL_W +: COUNT_W]);
            end
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int sent;
        int phase;
        int span;
        int pick;
        for (int ch = 0; ch < N_CH; ch++) begin
            dark_acc[ch] = '0;
            lit_acc[ch] = '0;
            level_now[ch] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].settle >= 0)
                write_settle(SETTLE_W'(plan[i].settle));
            offer_word(plan[i].smp, plan[i].typed);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            // long extreme settle, then zero so the next tick is final
            case (phase)
                0: begin pick = 255; span = 500; end
                1: begin pick = 0;   span = 150; end
                2: begin pick = 1;   span = 120; end
                default: begin
                    case ($urandom_range(0, 9))
                        0: pick = 0;
                        1: pick = 255;
                        default: pick = $urandom_range(1, 24);
                    endcase
                    span = $urandom_range(40, 200);
                end
            endcase
            if (phase != 0 || sent != 0)
                write_settle(SETTLE_W'(pick));
            else
                write_settle(SETTLE_W'(pick));
            new_scene();
            if (span > RANDOM_WORDS - sent)
                span = RANDOM_WORDS - sent;
            repeat (span) begin
                if (sent >= RANDOM_WORDS - CALM_TAIL)
                    calm = 1'b1;
                if ($urandom_range(0, 63) == 0)
                    new_scene();
                offer_word(draw_samples(), 1'b0);
                sent++;
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
